/* rtl/reno_cw_pkg.sv */
`default_nettype none

package reno_cw_pkg;

    // event kinds
    localparam logic CMD_ACK     = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    // phase codes
    localparam logic PH_SLOW_START = 1'b0;
    localparam logic PH_AVOID      = 1'b1;

    localparam logic [15:0] CWND_MAX       = 16'hFFFF;
    localparam logic [15:0] CWND_RESET     = 16'd1;
    localparam logic [15:0] SSTHRESH_RESET = 16'd10;
    localparam logic [15:0] LIMIT_RESET    = 16'd32;
    localparam logic [15:0] FR_INFLATE     = 16'd3;
    localparam logic [7:0]  DUP_MAX        = 8'hFF;
    localparam logic [7:0]  DUP_TRIGGER    = 8'd3;

    typedef struct packed {
        logic        phase;
        logic [15:0] cwnd;
        logic [15:0] ssthresh;
        logic [7:0]  dup_count;
        logic [31:0] last_ack;
        logic [15:0] avoid_accum;
    } t_cw_state;

    typedef struct packed {
        logic [15:0] cwnd;
        logic [15:0] ssthresh;
        logic        phase;
        logic        fast_rtx;
        logic [15:0] eff_window;
    } t_cw_result;

endpackage

`default_nettype wire

/* rtl/reno_cw_next.sv */
`default_nettype none

// Next-state and result logic for one event.
module reno_cw_next
    import reno_cw_pkg::*;
(
    input  wire t_cw_state   i_state,
    input  wire logic        i_cmd,
    input  wire logic [31:0] i_ack,
    input  wire logic [15:0] i_limit,
    output t_cw_state        o_state,
    output t_cw_result       o_result
);

    logic [15:0] halved;
    logic [15:0] thresh;
    logic [15:0] cwnd_inc;
    logic [15:0] accum_inc;
    logic [7:0]  dup_inc;
    logic        fired;
    t_cw_state   nxt;

    assign halved    = {1'b0, i_state.cwnd[15:1]};
    assign thresh    = (halved == 16'd0) ? 16'd1 : halved;
    assign cwnd_inc  = (i_state.cwnd == CWND_MAX) ? CWND_MAX : i_state.cwnd + 16'd1;
    assign accum_inc = (i_state.avoid_accum == CWND_MAX) ? CWND_MAX
                                                         : i_state.avoid_accum + 16'd1;
    assign dup_inc   = (i_state.dup_count == DUP_MAX) ? DUP_MAX
                                                      : i_state.dup_count + 8'd1;

    always_comb begin
        nxt   = i_state;
        fired = 1'b0;
        if (i_cmd == CMD_TIMEOUT) begin
            nxt.ssthresh    = thresh;
            nxt.cwnd        = CWND_RESET;
            nxt.phase       = PH_SLOW_START;
            nxt.avoid_accum = 16'd0;
        end else if (i_ack > i_state.last_ack) begin
            nxt.dup_count = 8'd0;
            nxt.last_ack  = i_ack;
            if (i_state.phase == PH_SLOW_START) begin
                nxt.cwnd = cwnd_inc;
                if (cwnd_inc >= i_state.ssthresh) begin
                    nxt.phase = PH_AVOID;
                end
            end else if (accum_inc >= i_state.cwnd) begin
                nxt.cwnd        = cwnd_inc;
                nxt.avoid_accum = 16'd0;
            end else begin
                nxt.avoid_accum = accum_inc;
            end
        end else if (i_ack == i_state.last_ack) begin
            nxt.dup_count = dup_inc;
            if (dup_inc == DUP_TRIGGER) begin
                // halved cwnd is at most 32767, so the inflate cannot overflow
                nxt.ssthresh    = thresh;
                nxt.cwnd        = thresh + FR_INFLATE;
                nxt.avoid_accum = 16'd0;
                nxt.phase       = PH_AVOID;
                fired           = 1'b1;
            end
        end
    end

    assign o_state             = nxt;
    assign o_result.cwnd       = nxt.cwnd;
    assign o_result.ssthresh   = nxt.ssthresh;
    assign o_result.phase      = nxt.phase;
    assign o_result.fast_rtx   = fired;
    assign o_result.eff_window = (i_limit < nxt.cwnd) ? i_limit : nxt.cwnd;

endmodule

`default_nettype wire

/* rtl/reno_congestion_window.sv */
`default_nettype none

// Channel   | Direction | Handshake          | Word
// ----------+-----------+--------------------+-------------------------------------------
// event in  | input     | i_valid / o_ready  | i_cmd, i_ack_number
// result    | output    | o_valid / i_ready  | o_congestion_window, o_slow_start_threshold,
//           |           |                    | o_phase, o_fast_retransmit, o_effective_window
// config    | input     | i_window_limit_we  | i_window_limit_wdata (no wait, no read-back)
//
// The event word is captured in the input register; the state update and result are
// then computed from it and stored together in the state and result registers.
// Throughput is one word per cycle while i_ready does not stall the result side; the
// only loop is the state register feeding its own combinational next-state logic.
// Reset (synchronous, active low) restores slow start, cwnd 1, ssthresh 10,
// no duplicates, last ACK 0 and a window limit of 32; both stages go empty.
// A stall on the result side holds both stages; o_ready follows i_ready when full.
module reno_congestion_window
    import reno_cw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_window_limit_we,
    input  wire logic [15:0] i_window_limit_wdata,

    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_cmd,
    input  wire logic [31:0] i_ack_number,

    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_congestion_window,
    output logic [15:0]      o_slow_start_threshold,
    output logic             o_phase,
    output logic             o_fast_retransmit,
    output logic [15:0]      o_effective_window
);

    // configuration
    logic [15:0] r_limit;

    // input stage
    logic        r_in_vld;
    logic        r_in_cmd;
    logic [31:0] r_in_ack;

    // congestion state
    t_cw_state   r_st;
    t_cw_state   n_st;

    // result stage
    logic        r_out_vld;
    t_cw_result  r_out;
    t_cw_result  n_out;

    logic        adv;       // result stage can take a word
    logic        fire;      // input stage word is processed this cycle

    assign adv     = !r_out_vld || i_ready;
    assign fire    = r_in_vld && adv;
    assign o_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_window_limit_we) begin
            r_limit <= i_window_limit_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_cmd <= i_cmd;
            r_in_ack <= i_ack_number;
        end
    end

    reno_cw_next u_next (
        .i_state  (r_st),
        .i_cmd    (r_in_cmd),
        .i_ack    (r_in_ack),
        .i_limit  (r_limit),
        .o_state  (n_st),
        .o_result (n_out)
    );

    // state commits when the word moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase       <= PH_SLOW_START;
            r_st.cwnd        <= CWND_RESET;
            r_st.ssthresh    <= SSTHRESH_RESET;
            r_st.dup_count   <= 8'd0;
            r_st.last_ack    <= 32'd0;
            r_st.avoid_accum <= 16'd0;
        end else if (fire) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_valid                = r_out_vld;
    assign o_congestion_window    = r_out.cwnd;
    assign o_slow_start_threshold = r_out.ssthresh;
    assign o_phase                = r_out.phase;
    assign o_fast_retransmit      = r_out.fast_rtx;
    assign o_effective_window     = r_out.eff_window;

`ifndef SYNTHESIS
    // cwnd and ssthresh never reach zero
    a_cwnd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.cwnd != 16'd0) && (r_st.ssthresh != 16'd0))
        else $error("cwnd or ssthresh reached zero");

    // a stalled input word is neither lost nor altered
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !adv) |=> (r_in_vld && $stable(r_in_ack) && $stable(r_in_cmd)))
        else $error("input stage dropped a stalled word");

    // state only moves when a word is processed
    a_state_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_st))
        else $error("state changed without an event");

    // fast retransmit always lands in avoidance
    a_frx_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.fast_rtx) |-> (r_out.phase == PH_AVOID))
        else $error("fast retransmit outside avoidance");

    // result reflects the committed window state
    a_out_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_out.cwnd == r_st.cwnd) && (r_out.ssthresh == r_st.ssthresh))
        else $error("result out of step with state");
`endif

endmodule

`default_nettype wire
